// ----- hdl/mps_pkg.sv -----
// Shared constants, command/status types and helpers of the Mandelbrot pixel shader.
package mps_pkg;

    localparam int MAX_SIZE_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 27;

    localparam int WORD_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int SIZE_CFG_W = 11;
    localparam int PIX_W      = 10;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;

    // |max - min| * pixel index fits in 32 + 10 bits
    localparam int MAG_W = WORD_W + PIX_W;
    // 255 * (iteration count) fits in 24 bits
    localparam int COL_W = LIMIT_W + CHAN_W;

    localparam logic signed [WORD_W-1:0] RST_REAL_MIN = -32'sd268435456;
    localparam logic signed [WORD_W-1:0] RST_REAL_MAX = 32'sd134217728;
    localparam logic signed [WORD_W-1:0] RST_IMAG_MIN = -32'sd201326592;
    localparam logic signed [WORD_W-1:0] RST_IMAG_MAX = 32'sd201326592;
    localparam logic [LIMIT_W-1:0]       RST_LIMIT    = 16'd16;
    localparam logic [SIZE_CFG_W-1:0]    RST_WIDTH    = 11'd32;
    localparam logic [SIZE_CFG_W-1:0]    RST_HEIGHT   = 11'd32;

    localparam int              ESCAPE_R2   = 9;
    localparam logic [CHAN_W-1:0] SCALE_RG  = 8'd255;
    localparam logic [CHAN_W-1:0] SCALE_B   = 8'd80;
    localparam logic [CHAN_W-1:0] ALPHA_IN  = 8'd32;
    localparam logic [CHAN_W-1:0] ALPHA_OUT = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_MIN,
        CFG_REAL_MAX,
        CFG_IMAG_MIN,
        CFG_IMAG_MAX,
        CFG_LIMIT,
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic map_mul;
        logic div_start;
        logic map_add;
        logic step;
        logic square;
        logic col_mul;
        logic col_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic coord_done;
        logic col_done;
        logic div_busy;
        logic iterate;
        logic at_limit;
        logic out_free;
    } t_sts;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

// ----- hdl/mps_div.sv -----
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module mps_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;
    logic             last;

    assign sh    = {r_rem, r_quot[NUM_W-1]};
    assign diff  = sh - {1'b0, r_den};
    assign ge    = (sh >= {1'b0, r_den});
    assign n_rem = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    assign last  = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last && !i_start;
            r_busy <= i_start || (r_busy && !last);
        end
    end

    // shift the dividend out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], ge};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hdl/mps_datapath.sv -----
// Datapath: coordinate mapping, escape-time iteration, colour scaling and output register.
module mps_datapath #(
    parameter int MAX_SIZE  = mps_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = mps_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic signed [mps_pkg::WORD_W-1:0]       i_real_min,
    input  logic signed [mps_pkg::WORD_W-1:0]       i_real_max,
    input  logic signed [mps_pkg::WORD_W-1:0]       i_imag_min,
    input  logic signed [mps_pkg::WORD_W-1:0]       i_imag_max,
    input  logic        [mps_pkg::LIMIT_W-1:0]      i_limit,
    input  logic        [mps_pkg::SIZE_CFG_W-1:0]   i_width,
    input  logic        [mps_pkg::SIZE_CFG_W-1:0]   i_height,
    input  logic        [mps_pkg::PIX_W-1:0]        i_pixel_x,
    input  logic        [mps_pkg::PIX_W-1:0]        i_pixel_y,
    input  mps_pkg::t_cmd                           i_cmd,
    output mps_pkg::t_sts                           o_sts,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic        [mps_pkg::CHAN_W-1:0]       o_red,
    output logic        [mps_pkg::CHAN_W-1:0]       o_green,
    output logic        [mps_pkg::CHAN_W-1:0]       o_blue,
    output logic        [mps_pkg::CHAN_W-1:0]       o_alpha,
    output logic        [mps_pkg::LIMIT_W-1:0]      o_iteration_count
);

    localparam int WORD_W = mps_pkg::WORD_W;
    localparam int MAG_W  = mps_pkg::MAG_W;
    localparam int COL_W  = mps_pkg::COL_W;
    localparam int LIM_W  = mps_pkg::LIMIT_W;
    localparam int CHAN_W = mps_pkg::CHAN_W;
    localparam int SIZE_W = $clog2(MAX_SIZE);
    // width of x^2 / 2^FRAC_BITS, and of the sums built on it
    localparam int SQ_W   = 63 - FRAC_BITS;
    localparam int IT_W   = SQ_W + 3;
    localparam int SUM_W  = MAG_W + 2;

    function automatic logic [SIZE_W-1:0] divisor(input logic [mps_pkg::SIZE_CFG_W-1:0] s);
        if (s < 11'd2) begin
            return SIZE_W'(1);
        end else if (32'(s) > 32'(MAX_SIZE)) begin
            return SIZE_W'(MAX_SIZE - 1);
        end else begin
            return SIZE_W'(s - 11'd1);
        end
    endfunction

    logic [mps_pkg::PIX_W-1:0] r_px;
    logic [mps_pkg::PIX_W-1:0] r_py;
    logic                      r_neg_re;
    logic                      r_neg_im;
    logic [MAG_W-1:0]          r_mag_re;
    logic [MAG_W-1:0]          r_mag_im;
    logic signed [WORD_W-1:0]  r_cx;
    logic signed [WORD_W-1:0]  r_cy;
    logic signed [WORD_W-1:0]  r_x;
    logic signed [WORD_W-1:0]  r_y;
    logic signed [63:0]        r_pxx;
    logic signed [63:0]        r_pyy;
    logic signed [63:0]        r_pxy;
    logic [LIM_W-1:0]          r_n;
    logic [COL_W-1:0]          r_num_r;
    logic [COL_W-1:0]          r_num_g;
    logic [COL_W-1:0]          r_num_b;
    logic                      r_out_valid;
    logic [CHAN_W-1:0]         r_red;
    logic [CHAN_W-1:0]         r_green;
    logic [CHAN_W-1:0]         r_blue;
    logic [CHAN_W-1:0]         r_alpha;
    logic [LIM_W-1:0]          r_count;

    // coordinate mapping
    logic signed [WORD_W:0]   span_re;
    logic signed [WORD_W:0]   span_im;
    logic signed [MAG_W:0]    prod_re;
    logic signed [MAG_W:0]    prod_im;
    logic        [MAG_W:0]    prod_re_neg;
    logic        [MAG_W:0]    prod_im_neg;
    logic        [MAG_W-1:0]  quot_re;
    logic        [MAG_W-1:0]  quot_im;
    logic signed [SUM_W-1:0]  q_re;
    logic signed [SUM_W-1:0]  q_im;
    logic signed [SUM_W-1:0]  c_re_sum;
    logic signed [SUM_W-1:0]  c_im_sum;

    assign span_re = $signed({i_real_max[WORD_W-1], i_real_max})
                   - $signed({i_real_min[WORD_W-1], i_real_min});
    assign span_im = $signed({i_imag_max[WORD_W-1], i_imag_max})
                   - $signed({i_imag_min[WORD_W-1], i_imag_min});
    assign prod_re = span_re * $signed({1'b0, r_px});
    assign prod_im = span_im * $signed({1'b0, r_py});
    assign prod_re_neg = -prod_re;
    assign prod_im_neg = -prod_im;

    // truncating division: divide magnitudes, restore the sign afterwards
    assign q_re = r_neg_re ? -$signed({2'b00, quot_re}) : $signed({2'b00, quot_re});
    assign q_im = r_neg_im ? -$signed({2'b00, quot_im}) : $signed({2'b00, quot_im});
    assign c_re_sum = SUM_W'(i_real_min) + q_re;
    assign c_im_sum = SUM_W'(i_imag_min) + q_im;

    // escape-time iteration
    logic        [SQ_W-1:0]   x2;
    logic        [SQ_W-1:0]   y2;
    logic        [SQ_W:0]     r2_sum;
    logic        [SQ_W:0]     nine;
    logic signed [63:0]       xy_sh;
    logic signed [IT_W-1:0]   nx_w;
    logic signed [IT_W-1:0]   ny_w;

    assign x2     = r_pxx[62:FRAC_BITS];
    assign y2     = r_pyy[62:FRAC_BITS];
    assign r2_sum = {1'b0, x2} + {1'b0, y2};
    assign nine   = (SQ_W + 1)'(mps_pkg::ESCAPE_R2) << FRAC_BITS;
    assign xy_sh  = r_pxy >>> (FRAC_BITS - 1);
    assign nx_w   = $signed({3'b000, x2}) - $signed({3'b000, y2}) + IT_W'(r_cx);
    assign ny_w   = $signed(xy_sh[IT_W-1:0]) + IT_W'(r_cy);

    // colour scaling
    logic [LIM_W-1:0] rest;
    logic [COL_W-1:0] quot_r;
    logic [COL_W-1:0] quot_g;
    logic [COL_W-1:0] quot_b;
    logic             busy_re;
    logic             busy_im;
    logic             busy_r;
    logic             busy_g;
    logic             busy_b;
    logic             done_re;
    logic             done_im;
    logic             done_r;
    logic             done_g;
    logic             done_b;

    assign rest = i_limit - r_n;

    mps_div #(.NUM_W(MAG_W), .DEN_W(SIZE_W)) u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_mag_re),
        .i_den   (divisor(i_width)),
        .o_busy  (busy_re),
        .o_done  (done_re),
        .o_quot  (quot_re)
    );

    mps_div #(.NUM_W(MAG_W), .DEN_W(SIZE_W)) u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_mag_im),
        .i_den   (divisor(i_height)),
        .o_busy  (busy_im),
        .o_done  (done_im),
        .o_quot  (quot_im)
    );

    mps_div #(.NUM_W(COL_W), .DEN_W(LIM_W)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.col_start),
        .i_num   (r_num_r),
        .i_den   (i_limit),
        .o_busy  (busy_r),
        .o_done  (done_r),
        .o_quot  (quot_r)
    );

    mps_div #(.NUM_W(COL_W), .DEN_W(LIM_W)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.col_start),
        .i_num   (r_num_g),
        .i_den   (i_limit),
        .o_busy  (busy_g),
        .o_done  (done_g),
        .o_quot  (quot_g)
    );

    mps_div #(.NUM_W(COL_W), .DEN_W(LIM_W)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.col_start),
        .i_num   (r_num_b),
        .i_den   (i_limit),
        .o_busy  (busy_b),
        .o_done  (done_b),
        .o_quot  (quot_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.map_mul) begin
            r_neg_re <= prod_re[MAG_W];
            r_neg_im <= prod_im[MAG_W];
            r_mag_re <= prod_re[MAG_W] ? prod_re_neg[MAG_W-1:0] : prod_re[MAG_W-1:0];
            r_mag_im <= prod_im[MAG_W] ? prod_im_neg[MAG_W-1:0] : prod_im[MAG_W-1:0];
        end
        if (i_cmd.map_add) begin
            r_cx  <= mps_pkg::sat32(64'(c_re_sum));
            r_cy  <= mps_pkg::sat32(64'(c_im_sum));
            r_x   <= '0;
            r_y   <= '0;
            r_pxx <= '0;
            r_pyy <= '0;
            r_pxy <= '0;
            r_n   <= '0;
        end
        if (i_cmd.step) begin
            r_x <= mps_pkg::sat32(64'(nx_w));
            r_y <= mps_pkg::sat32(64'(ny_w));
            r_n <= r_n + LIM_W'(1);
        end
        if (i_cmd.square) begin
            r_pxx <= r_x * r_x;
            r_pyy <= r_y * r_y;
            r_pxy <= r_x * r_y;
        end
        if (i_cmd.col_mul) begin
            r_num_r <= COL_W'(r_n) * COL_W'(mps_pkg::SCALE_RG);
            r_num_g <= COL_W'(rest) * COL_W'(mps_pkg::SCALE_RG);
            r_num_b <= COL_W'(rest) * COL_W'(mps_pkg::SCALE_B);
        end
        if (i_cmd.out_load) begin
            r_count <= r_n;
            if (o_sts.at_limit) begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
                r_alpha <= mps_pkg::ALPHA_IN;
            end else begin
                r_red   <= quot_r[CHAN_W-1:0];
                r_green <= quot_g[CHAN_W-1:0];
                r_blue  <= quot_b[CHAN_W-1:0];
                r_alpha <= mps_pkg::ALPHA_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.coord_done = done_re & done_im;
    assign o_sts.col_done   = done_r & done_g & done_b;
    assign o_sts.div_busy   = busy_re | busy_im | busy_r | busy_g | busy_b;
    assign o_sts.iterate    = (r_n < i_limit) && !(r2_sum > nine);
    assign o_sts.at_limit   = (r_n >= i_limit);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_red             = r_red;
    assign o_green           = r_green;
    assign o_blue            = r_blue;
    assign o_alpha           = r_alpha;
    assign o_iteration_count = r_count;

    a_step_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_n < i_limit))
        else $error("iteration step issued at or beyond the limit");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before transfer");

endmodule

// ----- hdl/mps_ctrl.sv -----
// Controller: sequences mapping, iteration, colour scaling and output load for one pixel.
module mps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mps_pkg::t_sts i_sts,
    output mps_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_MUL,
        S_DIV_START,
        S_COORD_DIV,
        S_MAP_ADD,
        S_ITER_TEST,
        S_ITER_SQUARE,
        S_COL_MUL,
        S_COL_START,
        S_COL_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_MAP_MUL;
            end
            S_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_DIV_START;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_COORD_DIV;
            end
            S_COORD_DIV: begin
                if (i_sts.coord_done) n_state = S_MAP_ADD;
            end
            S_MAP_ADD: begin
                o_cmd.map_add = 1'b1;
                n_state       = S_ITER_TEST;
            end
            S_ITER_TEST: begin
                // advance one iteration, or leave once escaped or at the limit
                if (i_sts.iterate) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_ITER_SQUARE;
                end else if (i_sts.at_limit) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_COL_MUL;
                end
            end
            S_ITER_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ITER_TEST;
            end
            S_COL_MUL: begin
                o_cmd.col_mul = 1'b1;
                n_state       = S_COL_START;
            end
            S_COL_START: begin
                o_cmd.col_start = 1'b1;
                n_state         = S_COL_DIV;
            end
            S_COL_DIV: begin
                if (i_sts.col_done) n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_coord_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.coord_done |-> (r_state == S_COORD_DIV))
        else $error("coordinate division finished outside its wait state");

    a_dividers_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.div_busy)
        else $error("divider still running while ready for a new pixel");

endmodule

// ----- hdl/mandelbrot_pixel_shader_top.sv -----
// A pixel passes the 42-step coordinate dividers, then for each iteration a step state and
// a state through the squaring multipliers, then the 24-step colour dividers, which a
// pixel that reaches the limit skips. One pixel is worked at a time: a new one is taken
// once the last has been loaded into the output register, while its result waits there.
// Reset is synchronous, active low: the window and limits return to their defaults,
// nothing pends.
module mandelbrot_pixel_shader_top #(
    parameter int MAX_SIZE  = mps_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = mps_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mps_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mps_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [mps_pkg::PIX_W-1:0]         i_pixel_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mps_pkg::CHAN_W-1:0]        o_red,
    output logic [mps_pkg::CHAN_W-1:0]        o_green,
    output logic [mps_pkg::CHAN_W-1:0]        o_blue,
    output logic [mps_pkg::CHAN_W-1:0]        o_alpha,
    output logic [mps_pkg::LIMIT_W-1:0]       o_iteration_count
);

    logic signed [mps_pkg::WORD_W-1:0]     r_real_min;
    logic signed [mps_pkg::WORD_W-1:0]     r_real_max;
    logic signed [mps_pkg::WORD_W-1:0]     r_imag_min;
    logic signed [mps_pkg::WORD_W-1:0]     r_imag_max;
    logic        [mps_pkg::LIMIT_W-1:0]    r_limit;
    logic        [mps_pkg::SIZE_CFG_W-1:0] r_width;
    logic        [mps_pkg::SIZE_CFG_W-1:0] r_height;

    mps_pkg::t_cmd cmd;
    mps_pkg::t_sts sts;

    // register file; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_min <= mps_pkg::RST_REAL_MIN;
            r_real_max <= mps_pkg::RST_REAL_MAX;
            r_imag_min <= mps_pkg::RST_IMAG_MIN;
            r_imag_max <= mps_pkg::RST_IMAG_MAX;
            r_limit    <= mps_pkg::RST_LIMIT;
            r_width    <= mps_pkg::RST_WIDTH;
            r_height   <= mps_pkg::RST_HEIGHT;
        end else if (i_cfg_valid) begin
            case (mps_pkg::t_cfg_idx'(i_cfg_index))
                mps_pkg::CFG_REAL_MIN: r_real_min <= i_cfg_data;
                mps_pkg::CFG_REAL_MAX: r_real_max <= i_cfg_data;
                mps_pkg::CFG_IMAG_MIN: r_imag_min <= i_cfg_data;
                mps_pkg::CFG_IMAG_MAX: r_imag_max <= i_cfg_data;
                mps_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data[mps_pkg::LIMIT_W-1:0];
                mps_pkg::CFG_WIDTH:    r_width    <= i_cfg_data[mps_pkg::SIZE_CFG_W-1:0];
                mps_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data[mps_pkg::SIZE_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    mps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mps_datapath #(
        .MAX_SIZE  (MAX_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_real_min        (r_real_min),
        .i_real_max        (r_real_max),
        .i_imag_min        (r_imag_min),
        .i_imag_max        (r_imag_max),
        .i_limit           (r_limit),
        .i_width           (r_width),
        .i_height          (r_height),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue),
        .o_alpha           (o_alpha),
        .o_iteration_count (o_iteration_count)
    );

endmodule

// ----- test/mandelbrot_pixel_shader_checker.sv -----
// Checker for the Mandelbrot pixel shader: window shadow, escape-time prediction, result compare.
`timescale 1ns / 1ps
module mandelbrot_pixel_shader_checker #(
    parameter int MAX_SIZE  = mps_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = mps_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mps_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [mps_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [mps_pkg::PIX_W-1:0]     i_pixel_y,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mps_pkg::CHAN_W-1:0]    i_red,
    input  logic [mps_pkg::CHAN_W-1:0]    i_green,
    input  logic [mps_pkg::CHAN_W-1:0]    i_blue,
    input  logic [mps_pkg::CHAN_W-1:0]    i_alpha,
    input  logic [mps_pkg::LIMIT_W-1:0]   i_iteration_count,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_compared
);

    localparam longint WORD_HI    = 64'sd2147483647;
    localparam longint WORD_LO    = -64'sd2147483648;
    localparam int     REPORT_CAP = 40;
    localparam int     CHAN_W     = mps_pkg::CHAN_W;
    localparam int     LIMIT_W    = mps_pkg::LIMIT_W;
    localparam int     WORD_W     = mps_pkg::WORD_W;
    localparam int     SIZE_CFG_W = mps_pkg::SIZE_CFG_W;
    localparam int     PIX_W      = mps_pkg::PIX_W;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [LIMIT_W-1:0] count;
    } t_shade;

    logic signed [WORD_W-1:0] re_lo;
    logic signed [WORD_W-1:0] re_hi;
    logic signed [WORD_W-1:0] im_lo;
    logic signed [WORD_W-1:0] im_hi;
    logic [LIMIT_W-1:0]       iter_max;
    logic [SIZE_CFG_W-1:0]    cols;
    logic [SIZE_CFG_W-1:0]    rows;

    t_shade shade_q[$];
    t_shade due_shade;
    int     fails    = 0;
    int     pending  = 0;
    int     compared = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_compared   = compared;

    function automatic longint clip_word(longint v);
        if (v > WORD_HI) return WORD_HI;
        if (v < WORD_LO) return WORD_LO;
        return v;
    endfunction

    // Linear map of a pixel index into the window; division truncates toward zero
    function automatic longint win_coord(longint lo, longint hi, longint idx, longint size);
        longint den;
        if (size < 2) begin
            den = 1;
        end else if (size > MAX_SIZE) begin
            den = MAX_SIZE - 1;
        end else begin
            den = size - 1;
        end
        return clip_word(lo + ((hi - lo) * idx) / den);
    endfunction

    function automatic t_shade shade_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        longint      cx;
        longint      cy;
        longint      zr;
        longint      zi;
        longint      zr2;
        longint      zi2;
        longint      nr;
        longint      ni;
        longint      bound;
        int unsigned n;
        int unsigned lim;
        int unsigned rest;
        t_shade      s;
        cx    = win_coord(re_lo, re_hi, px, cols);
        cy    = win_coord(im_lo, im_hi, py, rows);
        bound = longint'(mps_pkg::ESCAPE_R2) <<< FRAC_BITS;
        zr    = 0;
        zi    = 0;
        zr2   = 0;
        zi2   = 0;
        n     = 0;
        lim   = iter_max;
        while (n < lim && zr2 + zi2 <= bound) begin
            nr  = clip_word(zr2 - zi2 + cx);
            ni  = clip_word(((zr * zi) >>> (FRAC_BITS - 1)) + cy);
            zr  = nr;
            zi  = ni;
            // squares stay wide, no clamp
            zr2 = (zr * zr) >>> FRAC_BITS;
            zi2 = (zi * zi) >>> FRAC_BITS;
            n++;
        end
        s.count = LIMIT_W'(n);
        if (n >= lim) begin
            s.red   = '0;
            s.green = '0;
            s.blue  = '0;
            s.alpha = mps_pkg::ALPHA_IN;
        end else begin
            rest    = lim - n;
            s.red   = CHAN_W'((mps_pkg::SCALE_RG * n) / lim);
            s.green = CHAN_W'((mps_pkg::SCALE_RG * rest) / lim);
            s.blue  = CHAN_W'((mps_pkg::SCALE_B * rest) / lim);
            s.alpha = mps_pkg::ALPHA_OUT;
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [LIMIT_W-1:0] seen,
                                   logic [LIMIT_W-1:0] due);
        if (fails < REPORT_CAP) begin
            $display("%0t: %s mismatch at result %0d: got %0d, expected %0d",
                     $time, what, compared, seen, due);
        end
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_lo    = mps_pkg::RST_REAL_MIN;
            re_hi    = mps_pkg::RST_REAL_MAX;
            im_lo    = mps_pkg::RST_IMAG_MIN;
            im_hi    = mps_pkg::RST_IMAG_MAX;
            iter_max = mps_pkg::RST_LIMIT;
            cols     = mps_pkg::RST_WIDTH;
            rows     = mps_pkg::RST_HEIGHT;
            shade_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (shade_q.size() == 0) begin
                    report_mismatch("unrequested result, count", i_iteration_count, '0);
                end else begin
                    due_shade = shade_q.pop_front();
                    if (i_red !== due_shade.red)
                        report_mismatch("red", i_red, due_shade.red);
                    if (i_green !== due_shade.green)
                        report_mismatch("green", i_green, due_shade.green);
                    if (i_blue !== due_shade.blue)
                        report_mismatch("blue", i_blue, due_shade.blue);
                    if (i_alpha !== due_shade.alpha)
                        report_mismatch("alpha", i_alpha, due_shade.alpha);
                    if (i_iteration_count !== due_shade.count)
                        report_mismatch("iteration count", i_iteration_count,
                                        due_shade.count);
                    compared++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mps_pkg::CFG_REAL_MIN: re_lo = i_cfg_data;
                    mps_pkg::CFG_REAL_MAX: re_hi = i_cfg_data;
                    mps_pkg::CFG_IMAG_MIN: im_lo = i_cfg_data;
                    mps_pkg::CFG_IMAG_MAX: im_hi = i_cfg_data;
                    mps_pkg::CFG_LIMIT:    iter_max = i_cfg_data[LIMIT_W-1:0];
                    mps_pkg::CFG_WIDTH:    cols = i_cfg_data[SIZE_CFG_W-1:0];
                    mps_pkg::CFG_HEIGHT:   rows = i_cfg_data[SIZE_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                shade_q.push_back(shade_pixel(i_pixel_x, i_pixel_y));
            end
        end
        pending = shade_q.size();
    end

endmodule

// ----- test/mandelbrot_pixel_shader_top_tb.sv -----
// Testbench top for the Mandelbrot pixel shader: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module mandelbrot_pixel_shader_top_tb;

    localparam int     HALF_PERIOD  = 6;
    localparam longint CYCLE_LIMIT  = 25_000_000;
    localparam int     SETTLE_GAP   = 4;
    localparam int     TAIL_CYCLES  = 200;
    localparam int     PHASES       = 3;
    localparam int     BLOCKS       = 17;
    localparam int     BLOCK_ITEMS  = 40;

    localparam int CFG_IDX_W = mps_pkg::CFG_IDX_W;
    localparam int WORD_W    = mps_pkg::WORD_W;
    localparam int LIMIT_W   = mps_pkg::LIMIT_W;
    localparam int PIX_W     = mps_pkg::PIX_W;
    localparam int CHAN_W    = mps_pkg::CHAN_W;
    localparam int SIZE_TOP  = mps_pkg::MAX_SIZE_DEF;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [WORD_W-1:0]    WORD_TOP  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0]    WORD_BOT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0]    Q_TWO     = 32'd268435456;
    localparam logic [LIMIT_W-1:0]   LIMIT_TOP = 16'hFFFF;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [WORD_W-1:0]    cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel_x    = '0;
    logic [PIX_W-1:0]     pixel_y    = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [CHAN_W-1:0]    alpha;
    logic [LIMIT_W-1:0]   iteration_count;

    int     fail_count;
    int     pending;
    int     compared;
    int     src_idle_pct = 6;
    int     snk_idle_pct = 78;
    int     pixels_sent  = 0;
    int     reg_writes   = 0;
    int     win_w        = 32;
    int     win_h        = 32;
    longint cycles       = 0;

    mandelbrot_pixel_shader_top uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_pixel_x         (pixel_x),
        .i_pixel_y         (pixel_y),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_red             (red),
        .o_green           (green),
        .o_blue            (blue),
        .o_alpha           (alpha),
        .o_iteration_count (iteration_count)
    );

    mandelbrot_pixel_shader_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_pixel_x         (pixel_x),
        .i_pixel_y         (pixel_y),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_red             (red),
        .i_green           (green),
        .i_blue            (blue),
        .i_alpha           (alpha),
        .i_iteration_count (iteration_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_compared        (compared)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Each write ends with valid low and an idle gap, so valid is never lowered and raised in one step
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(negedge clk);
    endtask

    // Leave valid high after the transfer; the next call or drain() decides what follows
    task automatic shade(int x, int y);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= PIX_W'(x);
        pixel_y  <= PIX_W'(y);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    function automatic int usable_size(int s);
        if (s < 2) return 2;
        if (s > SIZE_TOP) return SIZE_TOP;
        return s;
    endfunction

    task automatic new_setting();
        logic [WORD_W-1:0] rlo;
        logic [WORD_W-1:0] rhi;
        logic [WORD_W-1:0] ilo;
        logic [WORD_W-1:0] ihi;
        int                lim;
        int                w;
        int                h;
        int                pick;
        // mostly a window over the set, now and then anything at all
        if ($urandom_range(99) < 85) begin
            rlo = -int'($urandom_range(335544320, 67108864));
            rhi = $urandom_range(134217728, 26843546);
            ilo = -int'($urandom_range(201326592, 26843546));
            ihi = $urandom_range(201326592, 26843546);
        end else begin
            rlo = $urandom;
            rhi = $urandom;
            ilo = $urandom;
            ihi = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            lim = $urandom_range(32, 1);
        end else if (pick < 90) begin
            lim = $urandom_range(255, 33);
        end else begin
            lim = $urandom_range(1023, 256);
        end
        pick = $urandom_range(99);
        if (pick < 90) begin
            w = $urandom_range(SIZE_TOP, 2);
            h = $urandom_range(SIZE_TOP, 2);
        end else if (pick < 95) begin
            w = $urandom_range(1, 0);
            h = $urandom_range(1, 0);
        end else begin
            w = $urandom_range(2047, SIZE_TOP + 1);
            h = $urandom_range(2047, SIZE_TOP + 1);
        end
        write_reg(mps_pkg::CFG_REAL_MIN, rlo);
        write_reg(mps_pkg::CFG_REAL_MAX, rhi);
        write_reg(mps_pkg::CFG_IMAG_MIN, ilo);
        write_reg(mps_pkg::CFG_IMAG_MAX, ihi);
        write_reg(mps_pkg::CFG_LIMIT, WORD_W'(lim));
        write_reg(mps_pkg::CFG_WIDTH, WORD_W'(w));
        write_reg(mps_pkg::CFG_HEIGHT, WORD_W'(h));
        win_w = usable_size(w);
        win_h = usable_size(h);
    endtask

    initial begin
        int x;
        int y;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window: corners, bit patterns, a point inside and one beyond the image
        shade(0, 0);
        shade(31, 31);
        shade(16, 16);
        shade(682, 341);
        shade(341, 682);
        shade(1023, 1023);
        drain();

        write_reg(mps_pkg::CFG_LIMIT, '0);
        shade(5, 7);
        drain();
        write_reg(mps_pkg::CFG_LIMIT, 32'd1);
        shade(0, 0);
        drain();

        // sizes below two and above the maximum
        write_reg(mps_pkg::CFG_LIMIT, 32'd16);
        write_reg(mps_pkg::CFG_WIDTH, '0);
        write_reg(mps_pkg::CFG_HEIGHT, 32'd1);
        shade(1, 1);
        shade(3, 2);
        drain();
        write_reg(mps_pkg::CFG_WIDTH, 32'd2047);
        write_reg(mps_pkg::CFG_HEIGHT, 32'd1500);
        shade(1023, 0);
        shade(0, 1023);
        drain();

        // full-range window, reversed on the imaginary axis, so mapping saturates
        write_reg(mps_pkg::CFG_REAL_MIN, WORD_BOT);
        write_reg(mps_pkg::CFG_REAL_MAX, WORD_TOP);
        write_reg(mps_pkg::CFG_IMAG_MIN, WORD_TOP);
        write_reg(mps_pkg::CFG_IMAG_MAX, WORD_BOT);
        write_reg(mps_pkg::CFG_WIDTH, 32'd2);
        write_reg(mps_pkg::CFG_HEIGHT, 32'd2);
        shade(0, 0);
        shade(1, 1);
        shade(1023, 1023);
        shade(1023, 0);
        drain();

        // top limit: origin never escapes, a point at two escapes after two iterations
        write_reg(mps_pkg::CFG_LIMIT, WORD_W'(LIMIT_TOP));
        write_reg(mps_pkg::CFG_REAL_MIN, '0);
        write_reg(mps_pkg::CFG_REAL_MAX, '0);
        write_reg(mps_pkg::CFG_IMAG_MIN, '0);
        write_reg(mps_pkg::CFG_IMAG_MAX, '0);
        shade(0, 0);
        drain();
        write_reg(mps_pkg::CFG_REAL_MIN, Q_TWO);
        write_reg(mps_pkg::CFG_REAL_MAX, Q_TWO);
        write_reg(CFG_SPARE, $urandom);
        shade(0, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 6;
                    snk_idle_pct = 78;
                end
                1: begin
                    src_idle_pct = 78;
                    snk_idle_pct = 6;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int b = 0; b < BLOCKS; b++) begin
                drain();
                new_setting();
                for (int k = 0; k < BLOCK_ITEMS; k++) begin
                    // mostly inside the image, some beyond its edge
                    if ($urandom_range(99) < 85) begin
                        x = $urandom_range(win_w - 1, 0);
                        y = $urandom_range(win_h - 1, 0);
                    end else begin
                        x = $urandom_range(1023, 0);
                        y = $urandom_range(1023, 0);
                    end
                    shade(x, y);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Shaded %0d pixels under %0d register writes, %0d results compared.",
                 pixels_sent, reg_writes, compared);
        $display("Pacing went from receiver-heavy to sender-heavy stalls to none; %0d mismatches.",
                 fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
